/* hdl/sta_pkg.sv */
// Shared types and codes for the sparse triplet add/subtract block.
// No dependencies; imported by sta_ctrl and sparse_triplet_add_sub.
package sta_pkg;

	localparam int ROW_W = 10;
	localparam int COL_W = 10;
	localparam int VAL_W = 32;

	// input command codes; code 3 is unused and ignored
	typedef enum logic [1:0] {
		FUNC_LOAD_A = 2'd0,
		FUNC_LOAD_B = 2'd1,
		FUNC_START  = 2'd2
	} func_t;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_SUB = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_FIN
	} state_t;

	// one result transaction
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] val;
		logic             last;
		logic             empty_res;
		logic             overflow;
	} res_t;

endpackage

/* hdl/sta_store.sv */
// Triplet store: single write port, single read port, registered read data.
// Standalone; instantiated twice by sparse_triplet_add_sub.
module sta_store #(
	parameter int DEPTH  = 32,
	parameter int DATA_W = 52,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/sta_ctrl.sv */
// Load, merge sequencer and output stage for the triplet add/subtract block.
// Depends on sta_pkg; drives the two sta_store memories.
module sta_ctrl #(
	parameter int ENTRY_DEPTH = 32,
	parameter int INDEX_BITS  = 10,
	parameter int ADDR_W      = 5,
	parameter int CNT_W       = 6,
	parameter int DATA_W      = 52
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      op_mode,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                func,
	input  logic [sta_pkg::ROW_W-1:0] entry_row,
	input  logic [sta_pkg::COL_W-1:0] entry_col,
	input  logic [sta_pkg::VAL_W-1:0] entry_val,
	output logic                      we_a,
	output logic                      we_b,
	output logic [ADDR_W-1:0]         waddr,
	output logic [DATA_W-1:0]         wdata,
	output logic [ADDR_W-1:0]         raddr_a,
	output logic [ADDR_W-1:0]         raddr_b,
	input  logic [DATA_W-1:0]         rdata_a,
	input  logic [DATA_W-1:0]         rdata_b,
	output logic                      out_valid,
	input  logic                      out_ready,
	output sta_pkg::res_t             res
);

	import sta_pkg::*;

	localparam int EXT_W = INDEX_BITS + ROW_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ENTRY_DEPTH);

	typedef struct packed {
		logic in_ready;
		logic step_en;
		logic fin_en;
	} ctrl_t;

	state_t state_q, state_d;
	ctrl_t  ctl;

	logic [CNT_W-1:0] cnt_a_q, cnt_b_q, m_q, n_q;
	logic             ovf_q;
	logic             pend_valid_q, out_valid_q;
	res_t             pend_q, res_q, step_res, fin_res;

	logic accept, is_load_a, is_load_b, is_start, full_a, full_b;
	logic out_free, a_ok, b_ok, more, a_lt_b, a_eq_b, take_a, take_b, take_both;
	logic keep, load_out;

	logic [INDEX_BITS-1:0] a_row, a_col, b_row, b_col, sel_row, sel_col;
	logic [VAL_W-1:0]      a_val, b_val, sel_val;
	logic [EXT_W-1:0]      ld_row_ext, ld_col_ext, row_ext, col_ext;

	// input side
	assign accept    = in_valid && ctl.in_ready;
	assign is_load_a = (func == FUNC_LOAD_A);
	assign is_load_b = (func == FUNC_LOAD_B);
	assign is_start  = (func == FUNC_START);
	assign full_a    = (cnt_a_q >= DEPTH_C);
	assign full_b    = (cnt_b_q >= DEPTH_C);

	assign ld_row_ext = {{INDEX_BITS{1'b0}}, entry_row};
	assign ld_col_ext = {{INDEX_BITS{1'b0}}, entry_col};

	assign we_a  = accept && is_load_a && !full_a;
	assign we_b  = accept && is_load_b && !full_b;
	assign waddr = is_load_a ? cnt_a_q[ADDR_W-1:0] : cnt_b_q[ADDR_W-1:0];
	assign wdata = {ld_row_ext[INDEX_BITS-1:0], ld_col_ext[INDEX_BITS-1:0], entry_val};

	assign raddr_a = m_q[ADDR_W-1:0];
	assign raddr_b = n_q[ADDR_W-1:0];

	// heads of both stores
	assign a_row = rdata_a[DATA_W-1 -: INDEX_BITS];
	assign a_col = rdata_a[VAL_W +: INDEX_BITS];
	assign a_val = rdata_a[VAL_W-1:0];
	assign b_row = rdata_b[DATA_W-1 -: INDEX_BITS];
	assign b_col = rdata_b[VAL_W +: INDEX_BITS];
	assign b_val = rdata_b[VAL_W-1:0];

	assign a_ok   = (m_q < cnt_a_q);
	assign b_ok   = (n_q < cnt_b_q);
	assign more   = a_ok || b_ok;
	assign a_eq_b = (a_row == b_row) && (a_col == b_col);
	assign a_lt_b = (a_row < b_row) || ((a_row == b_row) && (a_col < b_col));

	assign take_a    = a_ok && (!b_ok || a_lt_b);
	assign take_b    = b_ok && (!a_ok || (!a_lt_b && !a_eq_b));
	assign take_both = a_ok && b_ok && a_eq_b;

	always_comb begin
		priority if (take_a) begin
			sel_row = a_row;
			sel_col = a_col;
			sel_val = a_val;
		end else if (take_b) begin
			sel_row = b_row;
			sel_col = b_col;
			sel_val = (op_mode == OP_SUB) ? (VAL_W'(0) - b_val) : b_val;
		end else begin
			sel_row = a_row;
			sel_col = a_col;
			sel_val = (op_mode == OP_SUB) ? (a_val - b_val) : (a_val + b_val);
		end
	end

	assign row_ext = {{ROW_W{1'b0}}, sel_row};
	assign col_ext = {{COL_W{1'b0}}, sel_col};

	always_comb begin
		step_res           = '0;
		step_res.row       = row_ext[ROW_W-1:0];
		step_res.col       = col_ext[COL_W-1:0];
		step_res.val       = sel_val;
		step_res.overflow  = ovf_q;
	end

	// closing transaction: the held survivor, or the empty marker
	always_comb begin
		if (pend_valid_q) begin
			fin_res = pend_q;
		end else begin
			fin_res           = '0;
			fin_res.empty_res = 1'b1;
			fin_res.overflow  = ovf_q;
		end
		fin_res.last = 1'b1;
	end

	assign keep     = (sel_val != '0);
	assign out_free = !out_valid_q || out_ready;
	// the held result goes out once a later survivor shows it is not last
	assign load_out = ctl.fin_en || (ctl.step_en && keep && pend_valid_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (!more) begin
					state_d = ST_FIN;
				end else if (out_free) begin
					state_d = ST_READ;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: ctl.in_ready = 1'b1;
			ST_READ: ctl = '0;
			ST_CMP:  ctl.step_en = more && out_free;
			ST_FIN:  ctl.fin_en = out_free;
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			m_q          <= '0;
			n_q          <= '0;
			ovf_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (ctl.fin_en) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (we_a) begin
					cnt_a_q <= cnt_a_q + CNT_W'(1);
				end
				if (we_b) begin
					cnt_b_q <= cnt_b_q + CNT_W'(1);
				end
				if (accept && ((is_load_a && full_a) || (is_load_b && full_b))) begin
					ovf_q <= 1'b1;
				end
			end

			if (accept && is_start) begin
				m_q <= '0;
				n_q <= '0;
			end else if (ctl.step_en) begin
				if (take_a || take_both) begin
					m_q <= m_q + CNT_W'(1);
				end
				if (take_b || take_both) begin
					n_q <= n_q + CNT_W'(1);
				end
			end

			if (ctl.fin_en) begin
				pend_valid_q <= 1'b0;
			end else if (ctl.step_en && keep) begin
				pend_valid_q <= 1'b1;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.step_en && keep) begin
			pend_q <= step_res;
		end
		if (ctl.fin_en) begin
			res_q <= fin_res;
		end else if (load_out) begin
			res_q <= pend_q;
		end
	end

	assign in_ready  = ctl.in_ready;
	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

/* hdl/sparse_triplet_add_sub.sv */
// Top level of the sparse matrix triplet add/subtract merge.
// Depends on sta_pkg, sta_store and sta_ctrl.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------------
//   input   | in_valid / in_ready   | func, entry_row, entry_col, entry_val
//   output  | out_valid / out_ready | out_row, out_col, out_val, last, empty_res,
//           |                       | overflow
//   config  | cfg_we (no wait)      | cfg_wdata -> op_mode
//
// A load transaction makes one write into store A or B, or, if that store is
// full, sets the overflow flag. A start transaction runs the merge: each step
// reads both store heads (ST_READ), then compares and advances (ST_CMP); a
// last read and compare finds both stores exhausted, then ST_FIN sends the closing transaction.
// The synchronous read of the stores is why each step has its own read state.
// in_ready is high only while no merge is running. Reset clears counts, the
// overflow flag and op_mode; store contents are not cleared.
// A stalled output holds the merge in place; the output register lets the
// next load transaction in while the final result waits to be taken.
module sparse_triplet_add_sub #(
	parameter int ENTRY_DEPTH = 32,
	parameter int INDEX_BITS  = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       func,
	input  logic [sta_pkg::ROW_W-1:0]        entry_row,
	input  logic [sta_pkg::COL_W-1:0]        entry_col,
	input  logic signed [sta_pkg::VAL_W-1:0] entry_val,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sta_pkg::ROW_W-1:0]        out_row,
	output logic [sta_pkg::COL_W-1:0]        out_col,
	output logic signed [sta_pkg::VAL_W-1:0] out_val,
	output logic                             last,
	output logic                             empty_res,
	output logic                             overflow,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata
);

	import sta_pkg::*;

	localparam int ADDR_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(ENTRY_DEPTH + 1);
	localparam int DATA_W = 2 * INDEX_BITS + VAL_W;

	logic              op_mode_q;
	logic              we_a, we_b;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [DATA_W-1:0] wdata, rdata_a, rdata_b;
	res_t              res;

	// op_mode: the user must write it only while the block is idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= OP_ADD;
		end else if (cfg_we) begin
			op_mode_q <= cfg_wdata;
		end
	end

	sta_store #(
		.DEPTH  (ENTRY_DEPTH),
		.DATA_W (DATA_W),
		.ADDR_W (ADDR_W)
	) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	sta_store #(
		.DEPTH  (ENTRY_DEPTH),
		.DATA_W (DATA_W),
		.ADDR_W (ADDR_W)
	) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	sta_ctrl #(
		.ENTRY_DEPTH (ENTRY_DEPTH),
		.INDEX_BITS  (INDEX_BITS),
		.ADDR_W      (ADDR_W),
		.CNT_W       (CNT_W),
		.DATA_W      (DATA_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_mode   (op_mode_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.entry_row (entry_row),
		.entry_col (entry_col),
		.entry_val (entry_val),
		.we_a      (we_a),
		.we_b      (we_b),
		.waddr     (waddr),
		.wdata     (wdata),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// unpack the result transaction onto its ports
	assign out_row   = res.row;
	assign out_col   = res.col;
	assign out_val   = res.val;
	assign last      = res.last;
	assign empty_res = res.empty_res;
	assign overflow  = res.overflow;

endmodule
